// ===== design/svps_pkg.sv =====
// Shared constants and types for the servo pulse sequencer.
`timescale 1ns / 1ps
`default_nettype none
package svps_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_W         = 3;   // channel number field width
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int WIDTH_W      = 8;   // pulse width / slot length / tick counter
    localparam int LINES_W      = 8;

    localparam logic [WIDTH_W-1:0] SLOT_RESET  = 8'd155;
    localparam logic [LINES_W-1:0] LINES_RESET = 8'h01;

    // input kind carried in tuser
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef struct packed {
        logic               en;
        logic [CH_W-1:0]    ch;
        logic [WIDTH_W-1:0] value;
    } t_wr_req;

    typedef struct packed {
        logic            advance;   // slot moves to the next channel
        logic [CH_W-1:0] slot;      // current channel
    } t_slot_ctl;

    // next channel with wrap
    function automatic logic [CH_W-1:0] next_ch(input logic [CH_W-1:0] ch);
        logic [CH_W:0] inc;
        inc = {1'b0, ch} + {{CH_W{1'b0}}, 1'b1};
        if (inc >= (CH_W+1)'(NUM_CHANNELS)) begin
            next_ch = '0;
        end else begin
            next_ch = inc[CH_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/svps_width_store.sv =====
// Channel width table with shadow copies for the current and next channel.
`timescale 1ns / 1ps
`default_nettype none
module svps_width_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire svps_pkg::t_wr_req             i_wr,
    input  wire svps_pkg::t_slot_ctl           i_ctl,
    output logic [svps_pkg::WIDTH_W-1:0]       o_w_cur,
    output logic [svps_pkg::WIDTH_W-1:0]       o_w_next
);
    import svps_pkg::*;

    logic [WIDTH_W-1:0] r_table [NUM_CHANNELS];
    logic [WIDTH_W-1:0] r_w_cur, r_w_next;
    logic [CH_W-1:0]    slot_n1, slot_n2;
    logic               wr_ok;

    assign slot_n1 = next_ch(i_ctl.slot);
    assign slot_n2 = next_ch(slot_n1);
    assign wr_ok   = i_wr.en && ({1'b0, i_wr.ch} < (CH_W+1)'(NUM_CHANNELS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_table[i] <= SLOT_RESET;
            end
        end else if (wr_ok) begin
            r_table[i_wr.ch[CH_IDX_W-1:0]] <= i_wr.value;
        end
    end

    // shadows: writes and slot advances never share a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_cur  <= SLOT_RESET;
            r_w_next <= SLOT_RESET;
        end else if (i_ctl.advance) begin
            r_w_cur  <= r_w_next;
            r_w_next <= r_table[slot_n2[CH_IDX_W-1:0]];
        end else if (wr_ok) begin
            if (i_wr.ch == i_ctl.slot) r_w_cur  <= i_wr.value;
            if (i_wr.ch == slot_n1)    r_w_next <= i_wr.value;
        end
    end

    assign o_w_cur  = r_w_cur;
    assign o_w_next = r_w_next;

endmodule
`default_nettype wire

// ===== design/svps_seq_core.sv =====
// Tick counter, phase control and servo line levels.
`timescale 1ns / 1ps
`default_nettype none
module svps_seq_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_tick,
    input  wire logic [svps_pkg::WIDTH_W-1:0]  i_slot_length,
    input  wire logic [svps_pkg::WIDTH_W-1:0]  i_w_cur,
    input  wire logic [svps_pkg::WIDTH_W-1:0]  i_w_next,
    output svps_pkg::t_slot_ctl                o_ctl,
    output logic [svps_pkg::LINES_W-1:0]       o_n_lines,
    output logic [svps_pkg::CH_W-1:0]          o_n_slot,
    output logic                               o_n_low
);
    import svps_pkg::*;

    logic [WIDTH_W-1:0] r_tick_cnt, n_tick_cnt;
    logic [WIDTH_W-1:0] r_compare,  n_compare;
    logic [CH_W-1:0]    r_slot,     n_slot;
    logic               r_low,      n_low;
    logic [LINES_W-1:0] r_lines,    n_lines;
    logic [CH_W-1:0]    slot_n1;
    logic               advance;

    assign slot_n1 = next_ch(r_slot);

    always_comb begin
        n_tick_cnt = r_tick_cnt;
        n_compare  = r_compare;
        n_slot     = r_slot;
        n_low      = r_low;
        n_lines    = r_lines;
        advance    = 1'b0;
        if (i_tick) begin
            if (r_tick_cnt == r_compare) begin
                n_tick_cnt = '0;
                if (!r_low && (i_w_cur != i_slot_length)) begin
                    // high phase ends: drop line, run low remainder
                    n_compare = (i_w_cur < i_slot_length) ? (i_slot_length - i_w_cur) : '0;
                    n_low     = 1'b1;
                    n_lines   = r_lines ^ (LINES_W'(1) << r_slot);
                end else begin
                    // low phase done or idle channel: move on
                    advance   = 1'b1;
                    n_low     = 1'b0;
                    n_slot    = slot_n1;
                    n_compare = i_w_next;
                    if (i_w_next != i_slot_length) begin
                        n_lines = r_lines ^ (LINES_W'(1) << slot_n1);
                    end
                end
            end else begin
                n_tick_cnt = r_tick_cnt + WIDTH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt <= '0;
            r_compare  <= SLOT_RESET;
            r_slot     <= '0;
            r_low      <= 1'b0;
            r_lines    <= LINES_RESET;
        end else begin
            r_tick_cnt <= n_tick_cnt;
            r_compare  <= n_compare;
            r_slot     <= n_slot;
            r_low      <= n_low;
            r_lines    <= n_lines;
        end
    end

    assign o_ctl.advance = advance;
    assign o_ctl.slot    = r_slot;
    assign o_n_lines     = n_lines;
    assign o_n_slot      = n_slot;
    assign o_n_low       = n_low;

endmodule
`default_nettype wire

// ===== design/multichannel_servo_pulse_sequencer.sv =====
// Top level of the multichannel servo pulse sequencer.
//
// Usage:
//  - Slave stream: each transfer is one item. tuser[0] selects the kind:
//    0 = one prescaled timer tick, 1 = write a channel width (clamped to the
//    slot length). tdata carries channel_sel and pulse_width.
//  - Master stream: exactly one result per item, giving the servo line levels,
//    the running channel and the low-phase flag after that item.
//  - Config: slot_length is written on any cycle with i_cfg_wr_en high;
//    change it only while no items are in flight.
//  - Path: each item is taken into the input register, then a single-pass
//    update writes its result into the result register.
//  - Throughput: one item per cycle while the master stream accepts results;
//    the width shadows and the single-pass state update let every item follow
//    the previous one directly.
//  - Stall: the result register holds while o_m_tvalid && !i_m_tready;
//    an empty input register takes one more item, then o_s_tready drops.
//  - Reset (synchronous, active low): all widths and slot length 155, channel
//    0 in its slot with its line high, counter zero, both registers empty.
`timescale 1ns / 1ps
`default_nettype none
module multichannel_servo_pulse_sequencer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [2:0] channel_sel, [10:3] pulse_width, rest 0
    input  wire logic [0:0]  i_s_tuser,   // [0] func
    // master stream
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [7:0] servo_lines, [10:8] current_channel,
                                          // [11] in_low_phase, rest 0
    // config
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data
);
    import svps_pkg::*;

    // slot length register
    logic [WIDTH_W-1:0] r_slot_length;

    // input register
    logic               r_in_valid;
    logic               r_in_func;
    logic [CH_W-1:0]    r_in_sel;
    logic [WIDTH_W-1:0] r_in_pw;

    // result register
    logic               r_out_valid;
    logic [15:0]        r_out_data;

    logic               advance;
    t_wr_req            wr;
    t_slot_ctl          ctl;
    logic [WIDTH_W-1:0] w_cur, w_next;
    logic [LINES_W-1:0] n_lines;
    logic [CH_W-1:0]    n_slot;
    logic               n_low;

    // item leaves the input register when the result register is free
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_length <= SLOT_RESET;
        end else if (i_cfg_wr_en) begin
            r_slot_length <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_func <= i_s_tuser[0];
            r_in_sel  <= i_s_tdata[CH_W-1:0];
            r_in_pw   <= i_s_tdata[CH_W+WIDTH_W-1:CH_W];
        end
    end

    // width write request, clamped to the slot length
    assign wr.en    = advance && (r_in_func == FUNC_WRITE);
    assign wr.ch    = r_in_sel;
    assign wr.value = (r_in_pw > r_slot_length) ? r_slot_length : r_in_pw;

    svps_width_store u_width_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr),
        .i_ctl    (ctl),
        .o_w_cur  (w_cur),
        .o_w_next (w_next)
    );

    svps_seq_core u_seq_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (advance && (r_in_func == FUNC_TICK)),
        .i_slot_length (r_slot_length),
        .i_w_cur       (w_cur),
        .i_w_next      (w_next),
        .o_ctl         (ctl),
        .o_n_lines     (n_lines),
        .o_n_slot      (n_slot),
        .o_n_low       (n_low)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {4'b0000, n_low, n_slot, n_lines};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule
`default_nettype wire
